// ===== design/decaying_obstacle_grid_top_macros.svh =====
`ifndef DECAYING_OBSTACLE_GRID_TOP_MACROS_SVH
`define DECAYING_OBSTACLE_GRID_TOP_MACROS_SVH

// Same-cycle implication, checked on aclk while aresetn is high.
`define DOG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("grid assertion violated");

// Next-cycle implication, checked on aclk while aresetn is high.
`define DOG_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("grid assertion violated");

`endif

// ===== design/dog_pkg.sv =====
`timescale 1ns / 1ps

package dog_pkg;

    localparam int GRID_COLS_MAX  = 512;
    localparam int GRID_ROWS_MAX  = 512;
    localparam int LOCAL_SIZE_MAX = 1024;

    localparam int COL_W      = $clog2(GRID_COLS_MAX);
    localparam int ROW_W      = $clog2(GRID_ROWS_MAX);
    localparam int ADDR_W     = COL_W + ROW_W;
    localparam int LOCAL_W    = $clog2(LOCAL_SIZE_MAX);
    localparam int DIM_W      = 10;

    // Q.17 accumulator for the grid mapping.
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = LOCAL_W + 2;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int FRAC_W  = 17;

    localparam logic [1:0] OP_STAMP = 2'd0;
    localparam logic [1:0] OP_DECAY = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [2:0] CFG_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_DECAY     = 3'd1;
    localparam logic [2:0] CFG_STEP_COS  = 3'd2;
    localparam logic [2:0] CFG_STEP_SIN  = 3'd3;
    localparam logic [2:0] CFG_SHIFT_X   = 3'd4;
    localparam logic [2:0] CFG_SHIFT_Y   = 3'd5;
    localparam logic [2:0] CFG_WIDTH     = 3'd6;
    localparam logic [2:0] CFG_HEIGHT    = 3'd7;

    localparam logic [6:0] STAMP_BLOCKED = 7'd100;

    localparam logic signed [7:0]  RST_THRESHOLD = 8'sd75;
    localparam logic [6:0]         RST_DECAY     = 7'd5;
    localparam logic signed [23:0] RST_STEP_COS  = 24'sd65536;
    localparam logic [DIM_W-1:0]   RST_DIM       = 10'd512;

    typedef struct packed {
        logic [1:0]         op;
        logic [LOCAL_W-1:0] local_col;
        logic [LOCAL_W-1:0] local_row;
        logic signed [7:0]  cost_value;
        logic [COL_W-1:0]   grid_col;
        logic [ROW_W-1:0]   grid_row;
    } in_t;

    typedef struct packed {
        logic [6:0]       cell_value;
        logic [COL_W-1:0] hit_col;
        logic [ROW_W-1:0] hit_row;
        logic             in_bounds;
        logic             over_threshold;
    } out_t;

    typedef struct packed {
        logic             done;
        logic             in_grid;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } xf_res_t;

endpackage

// ===== design/dog_xform.sv =====
`timescale 1ns / 1ps

module dog_xform (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [dog_pkg::LOCAL_W-1:0]     local_col,
    input  logic [dog_pkg::LOCAL_W-1:0]     local_row,
    input  logic signed [23:0]              step_cos,
    input  logic signed [23:0]              step_sin,
    input  logic signed [31:0]              shift_x,
    input  logic signed [31:0]              shift_y,
    input  logic [dog_pkg::DIM_W-1:0]       eff_w,
    input  logic [dog_pkg::DIM_W-1:0]       eff_h,
    output dog_pkg::xf_res_t                res
);

    localparam int ACC_W  = dog_pkg::ACC_W;
    localparam int FRAC_W = dog_pkg::FRAC_W;
    localparam int PROD_W = dog_pkg::PROD_W;
    localparam int Q_W    = ACC_W - FRAC_W;

    typedef enum logic [5:0] {
        STEP_COS_UX = 6'b000001,
        STEP_SIN_UY = 6'b000010,
        STEP_SIN_UX = 6'b000100,
        STEP_COS_UY = 6'b001000,
        STEP_LAST_Y = 6'b010000,
        STEP_CHECK  = 6'b100000
    } step_t;

    // True when a Q.17 coordinate truncates toward zero into [0, lim).
    function automatic logic axis_ok(input logic signed [ACC_W-1:0] a,
                                     input logic [dog_pkg::DIM_W-1:0] lim);
        logic [Q_W-1:0] q;
        logic           ok;
        q = a[ACC_W-1:FRAC_W];
        if (a[ACC_W-1]) begin
            // Points in (-1, 0) still land in cell zero.
            ok = (&q) && (|a[FRAC_W-1:0]);
        end else begin
            ok = q < Q_W'(lim);
        end
        return ok;
    endfunction

    logic                                busy_reg, busy_next;
    step_t                               step_reg, step_next;
    logic signed [dog_pkg::MUL_B_W-1:0]  ux_reg, ux_next;
    logic signed [dog_pkg::MUL_B_W-1:0]  uy_reg, uy_next;
    logic signed [PROD_W-1:0]            prod_reg, prod_next;
    logic                                neg_reg, neg_next;
    logic signed [ACC_W-1:0]             acc_reg, acc_next;
    logic signed [ACC_W-1:0]             ax_reg, ax_next;
    dog_pkg::xf_res_t                    res_reg, res_next;

    logic signed [dog_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [dog_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [ACC_W-1:0]             prod_ext;
    logic signed [ACC_W-1:0]             acc_sum;

    assign mul_a     = (step_reg == STEP_COS_UX || step_reg == STEP_COS_UY) ? step_cos : step_sin;
    assign mul_b     = (step_reg == STEP_COS_UX || step_reg == STEP_SIN_UX) ? ux_reg : uy_reg;
    assign prod_next = mul_a * mul_b;
    assign neg_next  = (step_reg == STEP_SIN_UY);
    assign prod_ext  = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign acc_sum   = neg_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        ux_next   = ux_reg;
        uy_next   = uy_reg;
        acc_next  = acc_reg;
        ax_next   = ax_reg;
        res_next  = res_reg;
        res_next.done = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_COS_UX;
            ux_next   = {1'b0, local_col, 1'b1};
            uy_next   = {1'b0, local_row, 1'b1};
        end else if (busy_reg) begin
            case (step_reg)
                STEP_COS_UX: begin
                    acc_next  = {{(ACC_W - 33){shift_x[31]}}, shift_x, 1'b0};
                    step_next = STEP_SIN_UY;
                end
                STEP_SIN_UY: begin
                    acc_next  = acc_sum;
                    step_next = STEP_SIN_UX;
                end
                STEP_SIN_UX: begin
                    ax_next   = acc_sum;
                    acc_next  = {{(ACC_W - 33){shift_y[31]}}, shift_y, 1'b0};
                    step_next = STEP_COS_UY;
                end
                STEP_COS_UY: begin
                    acc_next  = acc_sum;
                    step_next = STEP_LAST_Y;
                end
                STEP_LAST_Y: begin
                    acc_next  = acc_sum;
                    step_next = STEP_CHECK;
                end
                STEP_CHECK: begin
                    busy_next        = 1'b0;
                    step_next        = STEP_COS_UX;
                    res_next.done    = 1'b1;
                    res_next.in_grid = axis_ok(ax_reg, eff_w) && axis_ok(acc_reg, eff_h);
                    res_next.col     = ax_reg[ACC_W-1] ? '0
                                     : ax_reg[FRAC_W + dog_pkg::COL_W - 1:FRAC_W];
                    res_next.row     = acc_reg[ACC_W-1] ? '0
                                     : acc_reg[FRAC_W + dog_pkg::ROW_W - 1:FRAC_W];
                end
                default: begin
                    busy_next = 1'b0;
                    step_next = STEP_COS_UX;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= STEP_COS_UX;
            res_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            res_reg  <= res_next;
        end
        ux_reg   <= ux_next;
        uy_reg   <= uy_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
        ax_reg   <= ax_next;
    end

    assign res = res_reg;

endmodule

// ===== design/decaying_obstacle_grid_top.sv =====
`timescale 1ns / 1ps
// Obstacle-memory grid of 512 x 512 cells of 7 bits with max-merge stamping and decay.
// Input channel s_valid/s_ready/s_data carries one op: stamp a local cell, decay the
// whole grid, or read one grid cell. Every op yields exactly one transfer on
// m_valid/m_ready/m_data. Registers are written through cfg_wr_en/cfg_index/cfg_wdata;
// the user must write them only while the block is idle; the block does not enforce it.
// The block works on one item at a time. A stamp runs the grid mapping through one
// shared 24 x 12 multiplier and accumulator in six steps, then a read-modify-write of
// the cell on the grid memory, which a stamp that lands outside the grid skips. A decay
// sweeps the grid memory one cell per cycle. Ops that touch nothing (non-positive cost,
// unused code, read outside the grid) go straight to their result.
// After reset the grid memory is cleared one cell per cycle: s_ready stays low until
// the clear is done, while configuration writes are taken at once.
// A result waits in the output register while m_ready is low; the next item is
// still taken and is held in its last step until the output register frees.

module decaying_obstacle_grid_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  dog_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output dog_pkg::out_t                 m_data,
    input  logic                          cfg_wr_en,
    input  logic [2:0]                    cfg_index,
    input  logic [31:0]                   cfg_wdata
);

    localparam int ADDR_W = dog_pkg::ADDR_W;
    localparam int COL_W  = dog_pkg::COL_W;
    localparam int ROW_W  = dog_pkg::ROW_W;
    localparam int DIM_W  = dog_pkg::DIM_W;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_XFORM  = 7'b0000100,
        ST_READ   = 7'b0001000,
        ST_MERGE  = 7'b0010000,
        ST_DECAY  = 7'b0100000,
        ST_RESULT = 7'b1000000
    } state_t;

    // Configuration registers.
    logic signed [7:0]  thr_reg;
    logic [6:0]         decay_reg;
    logic signed [23:0] cos_reg;
    logic signed [23:0] sin_reg;
    logic signed [31:0] shift_x_reg;
    logic signed [31:0] shift_y_reg;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;

    state_t             state_reg, state_next;
    logic [ADDR_W:0]    cnt_reg, cnt_next;
    logic               is_stamp_reg, is_stamp_next;
    logic signed [7:0]  cost_reg, cost_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    dog_pkg::out_t      res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    dog_pkg::out_t      m_data_reg, m_data_next;
    logic               rd_pend_reg;
    logic [ADDR_W-1:0]  dwaddr_reg;
    logic [6:0]         rd_data_reg;

    logic [6:0]         grid_mem [dog_pkg::GRID_COLS_MAX * dog_pkg::GRID_ROWS_MAX];

    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [6:0]         wr_data;

    logic               in_xfer;
    logic               out_free;
    logic [DIM_W-1:0]   eff_w;
    logic [DIM_W-1:0]   eff_h;
    logic [6:0]         stamp_cost;
    logic [6:0]         merged;
    logic [6:0]         cell_sel;
    logic               over;
    logic [6:0]         decayed;
    logic               xf_start;
    dog_pkg::xf_res_t   xf_res;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign eff_w = (width_reg > DIM_W'(dog_pkg::GRID_COLS_MAX))
                 ? DIM_W'(dog_pkg::GRID_COLS_MAX) : width_reg;
    assign eff_h = (height_reg > DIM_W'(dog_pkg::GRID_ROWS_MAX))
                 ? DIM_W'(dog_pkg::GRID_ROWS_MAX) : height_reg;

    assign stamp_cost = (cost_reg >= thr_reg) ? dog_pkg::STAMP_BLOCKED : cost_reg[6:0];
    assign merged     = (stamp_cost > rd_data_reg) ? stamp_cost : rd_data_reg;
    assign cell_sel   = is_stamp_reg ? merged : rd_data_reg;
    assign over       = $signed({1'b0, cell_sel}) >= thr_reg;
    assign decayed    = (rd_data_reg > decay_reg) ? (rd_data_reg - decay_reg) : 7'd0;

    dog_xform u_xform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (xf_start),
        .local_col (s_data.local_col),
        .local_row (s_data.local_row),
        .step_cos  (cos_reg),
        .step_sin  (sin_reg),
        .shift_x   (shift_x_reg),
        .shift_y   (shift_y_reg),
        .eff_w     (eff_w),
        .eff_h     (eff_h),
        .res       (xf_res)
    );

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        is_stamp_next = is_stamp_reg;
        cost_next     = cost_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        xf_start      = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = {row_reg, col_reg};
        wr_en         = 1'b0;
        wr_addr       = cnt_reg[ADDR_W-1:0];
        wr_data       = 7'd0;

        case (state_reg)
            ST_CLEAR: begin
                wr_en    = 1'b1;
                cnt_next = cnt_reg + (ADDR_W + 1)'(1);
                if (&cnt_reg[ADDR_W-1:0]) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    res_next = '0;
                    case (s_data.op)
                        dog_pkg::OP_STAMP: begin
                            if (s_data.cost_value > 8'sd0) begin
                                is_stamp_next = 1'b1;
                                cost_next     = s_data.cost_value;
                                xf_start      = 1'b1;
                                state_next    = ST_XFORM;
                            end else begin
                                state_next = ST_RESULT;
                            end
                        end
                        dog_pkg::OP_DECAY: begin
                            cnt_next   = '0;
                            state_next = ST_DECAY;
                        end
                        dog_pkg::OP_READ: begin
                            is_stamp_next = 1'b0;
                            col_next      = s_data.grid_col;
                            row_next      = s_data.grid_row;
                            if (DIM_W'(s_data.grid_col) < eff_w
                                    && DIM_W'(s_data.grid_row) < eff_h) begin
                                state_next = ST_READ;
                            end else begin
                                res_next.hit_col = s_data.grid_col;
                                res_next.hit_row = s_data.grid_row;
                                state_next       = ST_RESULT;
                            end
                        end
                        default: begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_XFORM: begin
                if (xf_res.done) begin
                    if (xf_res.in_grid) begin
                        col_next   = xf_res.col;
                        row_next   = xf_res.row;
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_READ: begin
                rd_en      = 1'b1;
                state_next = ST_MERGE;
            end
            ST_MERGE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{cell_value: cell_sel, hit_col: col_reg, hit_row: row_reg,
                                     in_bounds: 1'b1, over_threshold: over};
                    if (is_stamp_reg && stamp_cost > rd_data_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = {row_reg, col_reg};
                        wr_data = stamp_cost;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_DECAY: begin
                // Reads run one cell ahead of the write-back of the decayed value.
                rd_en   = !cnt_reg[ADDR_W];
                rd_addr = cnt_reg[ADDR_W-1:0];
                if (rd_en) begin
                    cnt_next = cnt_reg + (ADDR_W + 1)'(1);
                end
                if (rd_pend_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = dwaddr_reg;
                    wr_data = decayed;
                end
                if (cnt_reg[ADDR_W] && !rd_pend_reg) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            grid_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= grid_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            rd_pend_reg <= (state_reg == ST_DECAY) && rd_en;
        end
        is_stamp_reg <= is_stamp_next;
        cost_reg     <= cost_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
        dwaddr_reg   <= rd_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg     <= dog_pkg::RST_THRESHOLD;
            decay_reg   <= dog_pkg::RST_DECAY;
            cos_reg     <= dog_pkg::RST_STEP_COS;
            sin_reg     <= '0;
            shift_x_reg <= '0;
            shift_y_reg <= '0;
            width_reg   <= dog_pkg::RST_DIM;
            height_reg  <= dog_pkg::RST_DIM;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                dog_pkg::CFG_THRESHOLD: thr_reg     <= cfg_wdata[7:0];
                dog_pkg::CFG_DECAY:     decay_reg   <= cfg_wdata[6:0];
                dog_pkg::CFG_STEP_COS:  cos_reg     <= cfg_wdata[23:0];
                dog_pkg::CFG_STEP_SIN:  sin_reg     <= cfg_wdata[23:0];
                dog_pkg::CFG_SHIFT_X:   shift_x_reg <= cfg_wdata;
                dog_pkg::CFG_SHIFT_Y:   shift_y_reg <= cfg_wdata;
                dog_pkg::CFG_WIDTH:     width_reg   <= cfg_wdata[DIM_W-1:0];
                dog_pkg::CFG_HEIGHT:    height_reg  <= cfg_wdata[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

`include "decaying_obstacle_grid_top_macros.svh"

    `DOG_ASSERT_IMP(a_no_write_idle, state_reg == ST_IDLE, !wr_en)
    `DOG_ASSERT_IMP(a_xform_done_in_xform, xf_res.done, state_reg == ST_XFORM)
    `DOG_ASSERT_IMP(a_decay_writes_back, state_reg == ST_DECAY && rd_pend_reg, wr_en)
    `DOG_ASSERT_IMP(a_hit_inside, m_valid_reg && m_data_reg.in_bounds,
        DIM_W'(m_data_reg.hit_col) < eff_w && DIM_W'(m_data_reg.hit_row) < eff_h)
    `DOG_ASSERT_NXT(a_stamp_starts_xform,
        in_xfer && s_data.op == dog_pkg::OP_STAMP && s_data.cost_value > 8'sd0,
        state_reg == ST_XFORM)

endmodule

// ===== sim/decaying_obstacle_grid_top_tb.sv =====
`timescale 1ns / 1ps

module decaying_obstacle_grid_top_tb;

    // The post-reset clear and every decay sweep run with no transfer.
    localparam int WATCHDOG_LIMIT = 1_200_000;
    localparam int COLS           = dog_pkg::GRID_COLS_MAX;
    localparam int ROWS           = dog_pkg::GRID_ROWS_MAX;
    localparam int GRID_CELLS     = COLS * ROWS;
    localparam int COL_W          = dog_pkg::COL_W;
    localparam int ROW_W          = dog_pkg::ROW_W;
    localparam int LOCAL_W        = dog_pkg::LOCAL_W;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_ITEMS    = 165;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic           aclk;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    dog_pkg::in_t   s_data;
    logic           m_valid;
    logic           m_ready;
    dog_pkg::out_t  m_data;
    logic           cfg_wr_en;
    logic [2:0]     cfg_index;
    logic [31:0]    cfg_wdata;

    decaying_obstacle_grid_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Shadow of the grid and of the registers as the block should hold them.
    bit   [6:0]        cost_cells [GRID_CELLS];
    logic signed [7:0] cur_threshold;
    logic [6:0]        cur_decay;
    logic signed [23:0] cur_cos;
    logic signed [23:0] cur_sin;
    logic signed [31:0] cur_shift_x;
    logic signed [31:0] cur_shift_y;
    logic [9:0]        cur_width;
    logic [9:0]        cur_height;

    dog_pkg::out_t cell_results_due [$];
    logic [17:0]   recent_hits [$];

    bit tx_live;
    bit tx_gaps_on;
    bit rx_stalls_on;
    int rx_hold      = 0;
    int quiet_cycles = 0;
    int mismatches   = 0;
    int n_results    = 0;
    int n_stamps     = 0;
    int n_stamp_hits = 0;
    int n_reads      = 0;
    int n_read_hits  = 0;
    int n_decays     = 0;
    int n_unused     = 0;
    int n_settings   = 0;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Computes the result of one operation and applies it to the shadow grid.
    function automatic dog_pkg::out_t apply_grid_op(input dog_pkg::in_t item);
        dog_pkg::out_t res;
        int     w, h, thr, cost, sv, cur_val, idx, i;
        longint ux, uy, c, s, sx, sy, ax, ay, gx, gy;
        res = '0;
        w = (cur_width > COLS) ? COLS : int'(cur_width);
        h = (cur_height > ROWS) ? ROWS : int'(cur_height);
        thr = cur_threshold;
        case (item.op)
            dog_pkg::OP_STAMP: begin
                cost = $signed(item.cost_value);
                if (cost > 0) begin
                    c  = cur_cos;
                    s  = cur_sin;
                    sx = cur_shift_x;
                    sy = cur_shift_y;
                    // Cell centres sit at odd half-steps, hence the doubled terms.
                    ux = 2 * longint'(item.local_col) + 1;
                    uy = 2 * longint'(item.local_row) + 1;
                    ax = c * ux - s * uy + 2 * sx;
                    ay = s * ux + c * uy + 2 * sy;
                    gx = ax / 131072;
                    gy = ay / 131072;
                    if (gx >= 0 && gx < w && gy >= 0 && gy < h) begin
                        idx     = int'(gy) * COLS + int'(gx);
                        sv      = (cost >= thr) ? int'(dog_pkg::STAMP_BLOCKED) : cost;
                        cur_val = cost_cells[idx];
                        if (sv > cur_val) begin
                            cur_val = sv;
                            cost_cells[idx] = 7'(cur_val);
                        end
                        res.cell_value     = 7'(cur_val);
                        res.hit_col        = gx[COL_W-1:0];
                        res.hit_row        = gy[ROW_W-1:0];
                        res.in_bounds      = 1'b1;
                        res.over_threshold = (cur_val >= thr);
                    end
                end
            end
            dog_pkg::OP_DECAY: begin
                for (i = 0; i < GRID_CELLS; i++) begin
                    if (cost_cells[i] > cur_decay) cost_cells[i] = cost_cells[i] - cur_decay;
                    else cost_cells[i] = '0;
                end
            end
            dog_pkg::OP_READ: begin
                res.hit_col = item.grid_col;
                res.hit_row = item.grid_row;
                if (int'(item.grid_col) < w && int'(item.grid_row) < h) begin
                    cur_val = cost_cells[int'(item.grid_row) * COLS + int'(item.grid_col)];
                    res.cell_value     = 7'(cur_val);
                    res.in_bounds      = 1'b1;
                    res.over_threshold = (cur_val >= thr);
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic dog_pkg::in_t rand_item(input logic [1:0] op);
        dog_pkg::in_t it;
        it.op         = op;
        it.local_col  = LOCAL_W'($urandom);
        it.local_row  = LOCAL_W'($urandom);
        it.cost_value = 8'($urandom);
        it.grid_col   = COL_W'($urandom);
        it.grid_row   = ROW_W'($urandom);
        return it;
    endfunction

    function automatic dog_pkg::in_t stamp_item(input int lc, input int lr, input int cost);
        dog_pkg::in_t it;
        it = rand_item(dog_pkg::OP_STAMP);
        it.local_col  = LOCAL_W'(lc);
        it.local_row  = LOCAL_W'(lr);
        it.cost_value = 8'(cost);
        return it;
    endfunction

    function automatic dog_pkg::in_t read_item(input int gc, input int gr);
        dog_pkg::in_t it;
        it = rand_item(dog_pkg::OP_READ);
        it.grid_col = COL_W'(gc);
        it.grid_row = ROW_W'(gr);
        return it;
    endfunction

    task automatic log_mismatch(input string what, input dog_pkg::out_t due,
                                input dog_pkg::out_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display({"%0t %s: expected val=%0d col=%0d row=%0d inb=%0b over=%0b,",
                      " got val=%0d col=%0d row=%0d inb=%0b over=%0b"},
                     $time, what, due.cell_value, due.hit_col, due.hit_row, due.in_bounds,
                     due.over_threshold, got.cell_value, got.hit_col, got.hit_row,
                     got.in_bounds, got.over_threshold);
    endtask

    // Holds the item on the input channel until its transfer, then predicts its result.
    task automatic send_item(input dog_pkg::in_t item);
        int            gap;
        dog_pkg::out_t due;
        gap = tx_gaps_on ? idle_len() : 0;
        if (gap > 0) begin
            if (tx_live) s_valid <= 1'b0;
            tx_live = 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        tx_live = 1'b1;
        do @(posedge aclk); while (!s_ready);
        due = apply_grid_op(item);
        cell_results_due.insert(cell_results_due.size(), due);
        case (item.op)
            dog_pkg::OP_STAMP: begin
                n_stamps++;
                if (due.in_bounds) begin
                    n_stamp_hits++;
                    recent_hits.insert(recent_hits.size(), {due.hit_col, due.hit_row});
                    if (recent_hits.size() > 48) void'(recent_hits.pop_front());
                end
            end
            dog_pkg::OP_DECAY: n_decays++;
            dog_pkg::OP_READ: begin
                n_reads++;
                if (due.in_bounds) n_read_hits++;
            end
            default: n_unused++;
        endcase
    endtask

    task automatic wait_results_drained();
        if (tx_live) s_valid <= 1'b0;
        tx_live = 1'b0;
        while (cell_results_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // Writes every register once the block has gone idle.
    task automatic load_settings(input logic signed [7:0] thr, input logic [6:0] dec,
                                 input logic signed [23:0] c, input logic signed [23:0] s,
                                 input logic signed [31:0] sx, input logic signed [31:0] sy,
                                 input logic [9:0] w, input logic [9:0] h);
        wait_results_drained();
        write_reg(dog_pkg::CFG_THRESHOLD, 32'(thr));
        write_reg(dog_pkg::CFG_DECAY, 32'(dec));
        write_reg(dog_pkg::CFG_STEP_COS, 32'(c));
        write_reg(dog_pkg::CFG_STEP_SIN, 32'(s));
        write_reg(dog_pkg::CFG_SHIFT_X, sx);
        write_reg(dog_pkg::CFG_SHIFT_Y, sy);
        write_reg(dog_pkg::CFG_WIDTH, 32'(w));
        write_reg(dog_pkg::CFG_HEIGHT, 32'(h));
        cfg_wr_en <= 1'b0;
        cur_threshold = thr;
        cur_decay     = dec;
        cur_cos       = c;
        cur_sin       = s;
        cur_shift_x   = sx;
        cur_shift_y   = sy;
        cur_width     = w;
        cur_height    = h;
        n_settings++;
    endtask

    // Runs on the register values left by reset: identity mapping, threshold 75.
    task automatic test_reset_stamps();
        send_item(stamp_item(0, 0, 1));
        send_item(stamp_item(511, 511, 127));
        send_item(stamp_item(511, 511, 50));
        send_item(stamp_item(3, 5, 74));
        send_item(stamp_item(3, 5, 75));
        send_item(stamp_item(512, 0, 80));
        send_item(stamp_item(7, 7, 0));
        send_item(stamp_item(7, 7, -1));
        send_item(stamp_item(7, 7, -128));
        send_item(read_item(0, 0));
        send_item(read_item(511, 511));
        send_item(rand_item(OP_UNUSED));
    endtask

    task automatic test_decay_sweep();
        load_settings(8'sd75, 7'd37, 24'sd65536, 24'sd0, 32'sd0, 32'sd0, 10'd512, 10'd512);
        send_item(rand_item(dog_pkg::OP_DECAY));
        send_item(read_item(0, 0));
        send_item(read_item(511, 511));
        send_item(read_item(3, 5));
    endtask

    task automatic test_mapping_edges();
        // Mirrored x: the last in-range column lands in (-1,0) and truncates to zero.
        load_settings(8'sd75, 7'd5, -24'sd65536, 24'sd0, 511 * 65536, 32'sd0, 10'd512, 10'd512);
        send_item(stamp_item(511, 7, 20));
        send_item(stamp_item(512, 7, 20));
        send_item(stamp_item(0, 0, 90));
        send_item(read_item(0, 7));
        // Extreme transform with oversized grid dimensions, which saturate.
        load_settings(8'sh80, 7'd127, 24'sh7F_FFFF, 24'sh80_0000, 32'sh8000_0000,
                      32'sh7FFF_FFFF, 10'd1023, 10'd1023);
        send_item(stamp_item(1023, 1023, 1));
        send_item(read_item(511, 511));
        // A zero width puts every cell outside.
        load_settings(8'sd127, 7'd0, 24'sd65536, 24'sd0, 32'sd0, 32'sd0, 10'd0, 10'd512);
        send_item(read_item(0, 0));
        send_item(stamp_item(0, 0, 126));
        load_settings(8'sd0, 7'd5, 24'sd65536, 24'sd0, 32'sd0, 32'sd0, 10'd1, 10'd1);
        send_item(stamp_item(0, 0, 1));
        send_item(read_item(0, 0));
        send_item(read_item(1, 0));
    endtask

    task automatic test_random_traffic();
        int phase, k, r, span, base_c, base_r, lc, lr, cost;
        logic signed [7:0]  thr;
        logic [6:0]         dec;
        logic signed [23:0] c, s;
        logic signed [31:0] sx, sy;
        logic [9:0]         w, h;
        logic [17:0]        hit_pos;
        for (phase = 0; phase < 8; phase++) begin
            case (phase % 6)
                0: begin c = 24'sd65536; s = 24'sd0; sx = 0; sy = 0; span = 512; end
                1: begin
                    c = 24'sd32768; s = 24'sd0; span = 1024;
                    sx = $urandom_range(0, 65535);
                    sy = $urandom_range(0, 65535);
                end
                2: begin c = 24'sd0; s = 24'sd65536; sx = 512 * 65536; sy = 0; span = 512; end
                3: begin
                    c = 24'sd28378; s = 24'sd16384; span = 1024;
                    sx = 200 * 65536 + $urandom_range(0, 65535);
                    sy = 50 * 65536;
                end
                4: begin
                    c = -24'sd65536; s = 24'sd0; span = 512;
                    sx = 511 * 65536;
                    sy = $urandom_range(0, 65535);
                end
                default: begin
                    c = 24'($urandom); s = 24'($urandom); sx = $urandom; sy = $urandom;
                    span = 1024;
                end
            endcase
            case ($urandom_range(0, 4))
                0: thr = 8'sh80;
                1: thr = 8'sd127;
                2: thr = 8'sd0;
                3: thr = 8'sd75;
                default: thr = 8'($urandom);
            endcase
            if (phase == 1) dec = 7'd0;
            else if (phase == 3) dec = 7'd127;
            else dec = 7'($urandom_range(1, 60));
            w = 10'd512;
            h = 10'd512;
            if (phase == 4) begin
                w = 10'($urandom_range(1, 600));
                h = 10'($urandom_range(1, 600));
            end else if (phase == 7) begin
                w = 10'd1023;
                h = 10'($urandom_range(0, 1023));
            end
            load_settings(thr, dec, c, s, sx, sy, w, h);
            tx_gaps_on   = (phase == 1) || (phase > 2);
            rx_stalls_on = (phase >= 2);
            base_c = $urandom_range(0, span - 16);
            base_r = $urandom_range(0, span - 16);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (phase == 2 && k == 80) wait_results_drained();
                if (phase == 5 && k == 60) begin
                    send_item(rand_item(dog_pkg::OP_DECAY));
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 57) begin
                        r = $urandom_range(0, 99);
                        if (r < 45) begin
                            lc = base_c + $urandom_range(0, 15);
                            lr = base_r + $urandom_range(0, 15);
                        end else if (r < 85) begin
                            lc = $urandom_range(0, span - 1);
                            lr = $urandom_range(0, span - 1);
                        end else begin
                            lc = $urandom_range(0, 1023);
                            lr = $urandom_range(0, 1023);
                        end
                        if ($urandom_range(0, 99) < 80) cost = $urandom_range(1, 127);
                        else cost = -int'($urandom_range(0, 128));
                        send_item(stamp_item(lc, lr, cost));
                    end else if (r < 96) begin
                        if (recent_hits.size() != 0 && $urandom_range(0, 99) < 60) begin
                            hit_pos = recent_hits[$urandom_range(0, recent_hits.size() - 1)];
                            send_item(read_item(int'(hit_pos[17:9]), int'(hit_pos[8:0])));
                        end else begin
                            send_item(read_item($urandom_range(0, 511), $urandom_range(0, 511)));
                        end
                    end else if (r < 98) begin
                        send_item(rand_item(OP_UNUSED));
                    end else begin
                        send_item(rand_item(dog_pkg::OP_STAMP));
                    end
                end
            end
        end
    endtask

    always @(posedge aclk) begin : result_side
        dog_pkg::out_t due;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (cell_results_due.size() == 0) begin
                    log_mismatch("result with nothing outstanding", '0, m_data);
                end else begin
                    due = cell_results_due.pop_front();
                    if (due.cell_value !== m_data.cell_value || due.hit_col !== m_data.hit_col ||
                        due.hit_row !== m_data.hit_row || due.in_bounds !== m_data.in_bounds ||
                        due.over_threshold !== m_data.over_threshold)
                        log_mismatch("result differs", due, m_data);
                end
            end
            if (rx_hold > 0) begin
                m_ready <= 1'b0;
                rx_hold = rx_hold - 1;
            end else begin
                m_ready <= 1'b1;
                rx_hold = rx_stalls_on ? idle_len() : 0;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("decaying_obstacle_grid_top_tb: FAIL");
            $finish;
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        tx_live      = 1'b0;
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        cur_threshold = dog_pkg::RST_THRESHOLD;
        cur_decay     = dog_pkg::RST_DECAY;
        cur_cos       = dog_pkg::RST_STEP_COS;
        cur_sin       = '0;
        cur_shift_x   = '0;
        cur_shift_y   = '0;
        cur_width     = dog_pkg::RST_DIM;
        cur_height    = dog_pkg::RST_DIM;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_stamps();
        test_decay_sweep();
        test_mapping_edges();
        test_random_traffic();

        wait_results_drained();
        repeat (20) @(posedge aclk);
        $display("Covered %0d stamps (%0d in the grid), %0d reads (%0d inside),",
                 n_stamps, n_stamp_hits, n_reads, n_read_hits);
        $display("%0d decays, %0d unused ops, %0d register settings; %0d results, %0d bad.",
                 n_decays, n_unused, n_settings, n_results, mismatches);
        if (mismatches == 0) begin
            $display("decaying_obstacle_grid_top_tb: PASS");
        end else begin
            $display("decaying_obstacle_grid_top_tb: FAIL");
        end
        $finish;
    end

endmodule
